### hw/rtl/sraf_pkg.sv
// ----------------------------------------------------------------------------
// sraf_pkg: section address translation package
// Shared types and constants for the section rva to file offset block.
// ----------------------------------------------------------------------------
`default_nettype none

package sraf_pkg;

  // action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // fixed constants
  localparam logic [31:0] MISS_OFFSET = 32'hFFFF_FFFF;
  localparam logic [31:0] ADDR_LIMIT  = 32'h7FFF_FFFF;
  localparam int          COUNT_W     = 7;
  localparam int          ENTRY_W     = 96;

  // one input transaction
  typedef struct packed {
    logic        action;
    logic [5:0]  entry_index;
    logic [31:0] region_start;
    logic [31:0] region_size;
    logic [31:0] region_file_position;
    logic [31:0] query_address;
  } command_t;

  // one result transaction
  typedef struct packed {
    logic        found;
    logic [31:0] file_offset;
    logic [5:0]  match_index;
  } result_t;

  // one stored table entry
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic [31:0] position;
  } entry_t;

  // compare pipeline status toward the controller
  typedef struct packed {
    logic        done;
    logic        found;
    logic [31:0] file_offset;
    logic [5:0]  match_index;
  } match_t;

endpackage

`default_nettype wire

### hw/rtl/sraf_ram.sv
// ----------------------------------------------------------------------------
// sraf_ram: generic single-port-write ram
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sraf_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sraf_match.sv
// ----------------------------------------------------------------------------
// sraf_match: entry compare pipeline
// Two stages: end address and delta, then range check and file offset.
// ----------------------------------------------------------------------------
`default_nettype none

module sraf_match (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                flush,
  input  wire logic                                in_valid,
  input  wire logic [sraf_pkg::COUNT_W-1:0]        in_idx,
  input  wire sraf_pkg::entry_t                    entry,
  input  wire logic [31:0]                         query_address,
  input  wire logic [sraf_pkg::COUNT_W-1:0]        last_idx,
  output sraf_pkg::match_t                         status
);

  logic                              valid;
  logic [sraf_pkg::COUNT_W-1:0]      idx;
  logic [31:0]                       start;
  logic [31:0]                       stop;
  logic [31:0]                       delta;
  logic [31:0]                       position;
  logic                              hit;
  logic                              last;

  // stage one control
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  // stage one: region end and distance from start
  always_ff @(posedge clk) begin
    idx      <= in_idx;
    start    <= entry.start;
    stop     <= entry.start + entry.size;
    delta    <= query_address - entry.start;
    position <= entry.position;
  end

  // stage two: inclusive range check in either order
  always_comb begin
    hit  = ((query_address <= start) && (query_address >= stop)) ||
           ((query_address >= start) && (query_address <= stop));
    last = (idx == last_idx);
    status.done        = valid && (hit || last);
    status.found       = hit;
    status.file_offset = hit ? (delta + position) : sraf_pkg::MISS_OFFSET;
    status.match_index = hit ? idx[5:0] : 6'd0;
  end

endmodule

`default_nettype wire

### hw/rtl/section_rva_to_file_offset.sv
// ----------------------------------------------------------------------------
// section_rva_to_file_offset: section table address translation
// Holds section regions in a ram and scans them to map an address to an
// offset in the file image.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken when start is high and busy is low. A load command
//   writes one table entry in that cycle and produces no result; busy stays
//   low, so the next command may follow in the next cycle.
//   A query command with a valid address and count raises busy while entries
//   from 0 toward section_count-1 are read from the ram, one per cycle, into
//   a two-stage compare pipeline. The result strobes on result_valid for one
//   cycle. The scan stops at the first matching entry; a full miss answers
//   once entry section_count-1 has been compared. Queries that miss by
//   address or count answer in the next cycle. The rate is one entry per
//   cycle, set by the single ram read port.
//   section_count is written on the cfg channel while busy is low.
//   Reset clears section_count and the controller; table contents stay
//   undefined until loaded. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module section_rva_to_file_offset #(
  parameter int SECTIONS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire sraf_pkg::command_t    command,
  output logic                       result_valid,
  output sraf_pkg::result_t          result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [6:0]            cfg_data
);

  localparam int          ADDR_W   = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam logic [31:0] SECT_MAX = 32'(SECTIONS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                            state;
  logic [sraf_pkg::COUNT_W-1:0]      section_count;
  logic [sraf_pkg::COUNT_W-1:0]      last_idx;
  logic [sraf_pkg::COUNT_W-1:0]      rd_idx;
  logic [sraf_pkg::COUNT_W-1:0]      rd_tag;
  logic                              issuing;
  logic                              rd_valid;
  logic [31:0]                       qaddr;
  logic                              accept;
  logic                              load_we;
  logic                              query_ok;
  logic                              ren;
  sraf_pkg::entry_t                  wr_entry;
  sraf_pkg::entry_t                  rd_entry;
  sraf_pkg::match_t                  status;

  // handshake and decode
  always_comb begin
    busy      = (state == ST_SCAN);
    cfg_ready = !busy;
    accept    = start && !busy;
    load_we   = accept && (command.action == sraf_pkg::ACT_LOAD) &&
                (32'(command.entry_index) < SECT_MAX);
    query_ok  = (command.query_address != 32'd0) &&
                (command.query_address <= sraf_pkg::ADDR_LIMIT) &&
                (section_count != '0) &&
                (32'(section_count) <= SECT_MAX);
    last_idx  = section_count - 1'b1;
    ren       = (state == ST_SCAN) && issuing;
    wr_entry.start    = command.region_start;
    wr_entry.size     = command.region_size;
    wr_entry.position = command.region_file_position;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      section_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      section_count <= cfg_data;
    end
  end

  // section table; busy blocks loads while a scan reads it
  sraf_ram #(
    .WIDTH (sraf_pkg::ENTRY_W),
    .DEPTH (SECTIONS)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (ADDR_W'(command.entry_index)),
    .wdata (wr_entry),
    .re    (ren),
    .raddr (ADDR_W'(rd_idx)),
    .rdata (rd_entry)
  );

  // compare pipeline
  sraf_match u_match (
    .clk           (clk),
    .rst           (rst),
    .flush         (status.done),
    .in_valid      (rd_valid),
    .in_idx        (rd_tag),
    .entry         (rd_entry),
    .query_address (qaddr),
    .last_idx      (last_idx),
    .status        (status)
  );

  // scan controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      issuing  <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          rd_valid <= 1'b0;
          if (accept && (command.action == sraf_pkg::ACT_QUERY) && query_ok) begin
            state   <= ST_SCAN;
            issuing <= 1'b1;
          end
        end
        ST_SCAN: begin
          rd_valid <= issuing;
          if (issuing && (rd_idx == last_idx)) begin
            issuing <= 1'b0;
          end
          if (status.done) begin
            state    <= ST_IDLE;
            issuing  <= 1'b0;
            rd_valid <= 1'b0;
          end
        end
        default: begin
          state    <= ST_IDLE;
          issuing  <= 1'b0;
          rd_valid <= 1'b0;
        end
      endcase
    end
  end

  // scan address, tag and query address
  always_ff @(posedge clk) begin
    if (accept) begin
      qaddr  <= command.query_address;
      rd_idx <= '0;
    end else if (ren) begin
      rd_idx <= rd_idx + 1'b1;
    end
    rd_tag <= rd_idx;
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= status.done ||
                      (accept && (command.action == sraf_pkg::ACT_QUERY) && !query_ok);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (status.done) begin
      result.found       <= status.found;
      result.file_offset <= status.file_offset;
      result.match_index <= status.match_index;
    end else if (accept && !query_ok) begin
      result.found       <= 1'b0;
      result.file_offset <= sraf_pkg::MISS_OFFSET;
      result.match_index <= 6'd0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sraf_chk.sv
// ----------------------------------------------------------------------------
// sraf_chk: port level checker
// Watches the command and result channels of the translation block.
// ----------------------------------------------------------------------------
`default_nettype none

module sraf_chk (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire sraf_pkg::command_t command,
  input wire logic               result_valid,
  input wire sraf_pkg::result_t  result
);

  // a miss always carries the miss offset and index zero
  miss_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |->
      (result.file_offset == sraf_pkg::MISS_OFFSET) && (result.match_index == 6'd0))
    else $error("miss result with stale fields");

  // a query transaction either starts a scan or answers at once
  query_moves: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (command.action == sraf_pkg::ACT_QUERY) |=> busy || result_valid)
    else $error("query transaction lost");

  // a load transaction never yields a result and never blocks
  load_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (command.action == sraf_pkg::ACT_LOAD) |=> !busy && !result_valid)
    else $error("load transaction produced activity");

  // a scan ends exactly with its result
  scan_ends: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> result_valid)
    else $error("scan ended without result");

endmodule

bind section_rva_to_file_offset sraf_chk u_sraf_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .command      (command),
  .result_valid (result_valid),
  .result       (result)
);

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: section address translation testbench
// Loads section regions and sends address queries through a bursty driver.
// A monitor keeps a local copy of the section table and the count register,
// predicts each query's outcome and checks every strobed result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import sraf_pkg::*;

  localparam int SECTIONS = 64;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  command_t   command = '0;
  logic       result_valid;
  result_t    result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = '0;

  section_rva_to_file_offset #(.SECTIONS(SECTIONS)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // section table as the monitor sees it
  logic [31:0] sect_start [SECTIONS];
  logic [31:0] sect_size  [SECTIONS];
  logic [31:0] sect_pos   [SECTIONS];
  logic [6:0]  sect_count;

  // section table as the stimulus generator has planned it
  logic [31:0] plan_start  [SECTIONS];
  logic [31:0] plan_size   [SECTIONS];
  logic        plan_loaded [SECTIONS];

  command_t command_queue [$];
  result_t  awaited_translations [$];
  int       queued_total = 0;
  int       accepted_total = 0;
  int       fail_count = 0;
  logic     taken = 1'b0;
  int       burst_left = 1;
  int       gap_left = 0;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // expected outcome of one address query against the local table
  function automatic result_t translate_address(logic [31:0] addr);
    result_t     r;
    logic [31:0] lo;
    logic [31:0] hi;
    r.found       = 1'b0;
    r.file_offset = MISS_OFFSET;
    r.match_index = '0;
    if (addr != 32'd0 && addr <= ADDR_LIMIT && sect_count != 0 &&
        sect_count <= SECTIONS) begin
      for (int i = 0; i < sect_count; i++) begin
        lo = sect_start[i];
        hi = sect_start[i] + sect_size[i];
        if ((addr >= lo && addr <= hi) || (addr <= lo && addr >= hi)) begin
          r.found       = 1'b1;
          r.file_offset = addr - lo + sect_pos[i];
          r.match_index = 6'(i);
          return r;
        end
      end
    end
    return r;
  endfunction

  // driver: bursts of transactions separated by random gaps
  always @(negedge clk) begin
    // the current transaction stays on the port until taken
    if (!rst && (!start || taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (command_queue.size() > 0) begin
        command <= command_queue.pop_front();
        start   <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check results, then track config and accepted commands
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      taken      <= 1'b0;
      sect_count = '0;
    end else begin
      if (result_valid) begin
        if (awaited_translations.size() == 0) begin
          $error("result with no query outstanding: found %0d offset %h index %0d",
                 result.found, result.file_offset, result.match_index);
          fail_count++;
        end else begin
          want = awaited_translations.pop_front();
          if (result.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, result.found);
            fail_count++;
          end
          if (result.file_offset !== want.file_offset) begin
            $error("file_offset: expected %h, got %h", want.file_offset, result.file_offset);
            fail_count++;
          end
          if (result.match_index !== want.match_index) begin
            $error("match_index: expected %0d, got %0d", want.match_index, result.match_index);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready)
        sect_count = cfg_data;
      if (start && !busy) begin
        accepted_total++;
        if (command.action == ACT_LOAD) begin
          sect_start[command.entry_index] = command.region_start;
          sect_size[command.entry_index]  = command.region_size;
          sect_pos[command.entry_index]   = command.region_file_position;
        end else begin
          awaited_translations.push_back(translate_address(command.query_address));
        end
      end
      taken <= start && !busy;
    end
  end

  // load transaction, query field filled with noise
  task automatic queue_load(input logic [5:0] idx, input logic [31:0] base,
                            input logic [31:0] span, input logic [31:0] pos);
    command_t c;
    c.action               = ACT_LOAD;
    c.entry_index          = idx;
    c.region_start         = base;
    c.region_size          = span;
    c.region_file_position = pos;
    c.query_address        = $urandom;
    command_queue.push_back(c);
    queued_total++;
    plan_start[idx]  = base;
    plan_size[idx]   = span;
    plan_loaded[idx] = 1'b1;
  endtask

  // query transaction, load fields filled with noise
  task automatic queue_query(input logic [31:0] addr);
    command_t c;
    c.action               = ACT_QUERY;
    c.entry_index          = 6'($urandom);
    c.region_start         = $urandom;
    c.region_size          = $urandom;
    c.region_file_position = $urandom;
    c.query_address        = addr;
    command_queue.push_back(c);
    queued_total++;
  endtask

  // random region, biased toward a crowded low zone so entries overlap
  task automatic queue_region(input logic [5:0] idx);
    logic [31:0] base;
    logic [31:0] span;
    case ($urandom_range(0, 4))
      0, 1:    base = $urandom_range(32'h1000, 32'h2_0000);
      2, 3:    base = $urandom_range(0, ADDR_LIMIT);
      default: base = $urandom;
    endcase
    case ($urandom_range(0, 6))
      0, 1, 2, 3: span = $urandom_range(0, 32'h8000);
      4, 5:       span = $urandom_range(0, 32'h1000_0000);
      default:    span = $urandom;
    endcase
    queue_load(idx, base, span, $urandom);
  endtask

  // mostly addresses in or next to a live region, the rest edge values and noise
  function automatic logic [31:0] pick_address(int cnt);
    int          j;
    logic [63:0] span;
    logic [31:0] a;
    if (cnt >= 1 && cnt <= SECTIONS && $urandom_range(0, 9) < 6) begin
      j    = $urandom_range(0, cnt - 1);
      span = 64'(plan_size[j]) + 64'd1;
      case ($urandom_range(0, 5))
        0:       a = plan_start[j];
        1:       a = plan_start[j] + plan_size[j];
        2:       a = plan_start[j] + plan_size[j] + 32'd1;
        3:       a = plan_start[j] - 32'd1;
        default: a = plan_start[j] + 32'({$urandom, $urandom} % span);
      endcase
    end else begin
      case ($urandom_range(0, 7))
        0:       a = 32'd0;
        1:       a = ADDR_LIMIT;
        2:       a = ADDR_LIMIT + 32'd1;
        3, 4:    a = $urandom;
        default: a = $urandom_range(1, ADDR_LIMIT);
      endcase
    end
    return a;
  endfunction

  // wait for every queued transaction to be taken and every result to arrive
  task automatic wait_quiet();
    do @(negedge clk);
    while (accepted_total != queued_total || awaited_translations.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // section_count write on the config channel
  task automatic write_count(input logic [6:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stimulus
  initial begin
    int phase_counts [$] = '{64, 1, 127, 16, 0, 65, 64, 3, 40, 2, 64, 9, 0};
    int cnt;
    for (int i = 0; i < SECTIONS; i++)
      plan_loaded[i] = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // count still zero after reset: any query misses
    queue_query(32'h0000_1000);
    wait_quiet();

    // directed: overlap, inclusive ends, wrapped end, offset wrap, address limits
    write_count(7'd4);
    queue_load(6'd0, 32'h0000_1000, 32'h0000_0100, 32'h0000_0400);
    queue_load(6'd1, 32'h0000_1080, 32'h0000_0200, 32'h0000_0800);
    queue_load(6'd2, 32'h7FFF_FF00, 32'h0000_0200, 32'hFFFF_FFF0);
    queue_load(6'd3, 32'h0000_5000, 32'hFFFF_F000, 32'h1234_0000);
    queue_load(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_query(32'h0000_0000);
    queue_query(32'h0000_1000);
    queue_query(32'h0000_1100);
    queue_query(32'h0000_1090);
    queue_query(32'h0000_1101);
    queue_query(32'h7FFF_FF10);
    queue_query(ADDR_LIMIT);
    queue_query(ADDR_LIMIT + 32'd1);
    queue_query(32'hFFFF_FFFF);
    queue_query(32'h0000_4800);
    queue_query(32'h0000_3FFF);
    queue_query(32'h0000_0FFF);
    wait_quiet();

    // random phases, one count setting each; the last one picks its own count
    phase_counts.push_back($urandom_range(1, SECTIONS));
    foreach (phase_counts[p]) begin
      cnt = phase_counts[p];
      write_count(7'(cnt));
      // entries in use must be loaded before the first query searches them
      if (cnt <= SECTIONS) begin
        for (int i = 0; i < cnt; i++)
          if (!plan_loaded[i])
            queue_region(6'(i));
      end
      repeat (135) begin
        if ($urandom_range(0, 9) < 3)
          queue_region(6'($urandom_range(0, SECTIONS - 1)));
        else
          queue_query(pick_address(cnt));
      end
      wait_quiet();
    end

    // tail: let any stray result show up
    repeat (SECTIONS + 8) @(negedge clk);
    if (awaited_translations.size() != 0) begin
      $error("%0d results never arrived", awaited_translations.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
